/* rtl/rmq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_pkg: shared types and constants
// Widths, branch codes and the beat records that move down the cell chains.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int ElemW  = 18;
  localparam int TermW  = 20;   // sums/differences of two elements
  localparam int RadW   = 36;   // root argument << 14, always below 2^36
  localparam int RootW  = 18;   // floor(sqrt(RadW-bit value))
  localparam int NumW   = 35;   // |D| << 15 plus B
  localparam int DenW   = 19;   // 2 * B
  localparam int QuoW   = 35;   // quotient bits

  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_X     = 2'd1,
    BR_Y     = 2'd2,
    BR_Z     = 2'd3
  } branch_t;

  typedef struct packed {
    logic [RadW-1:0]  rem;
    logic [RootW-1:0] root;
    logic [RadW-1:0]  rad;
  } sqrt_beat_t;

  typedef struct packed {
    logic [NumW-1:0] rem;
    logic [QuoW-1:0] quo;
  } div_beat_t;

  typedef struct packed {
    logic                    valid;
    branch_t                 br;
    logic                    bad;
    logic signed [TermW-1:0] d0;
    logic signed [TermW-1:0] d1;
    logic signed [TermW-1:0] d2;
  } side_t;

endpackage

/* rtl/rmq_sqrt_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_sqrt_cell: one bit of a restoring square root
// Brings down two radicand bits, tries the next root bit, registers the beat.
// ----------------------------------------------------------------------------
module rmq_sqrt_cell #(
  parameter int Step = 0
) (
  input  logic               clk,
  input  rmq_pkg::sqrt_beat_t in_beat,
  output rmq_pkg::sqrt_beat_t out_beat
);
  import rmq_pkg::*;

  logic [RadW+1:0] rem_sh;
  logic [RadW+1:0] trial;
  sqrt_beat_t      beat_next;

  always_comb begin
    rem_sh = {in_beat.rem, in_beat.rad[RadW-1 -: 2]};
    trial  = {{(RadW-RootW){1'b0}}, in_beat.root, 2'b01};
    beat_next      = in_beat;
    beat_next.rad  = {in_beat.rad[RadW-3:0], 2'b00};
    if (rem_sh >= trial) begin
      beat_next.rem  = RadW'(rem_sh - trial);
      beat_next.root = {in_beat.root[RootW-2:0], 1'b1};
    end else begin
      beat_next.rem  = RadW'(rem_sh);
      beat_next.root = {in_beat.root[RootW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    out_beat <= beat_next;
  end

endmodule

/* rtl/rmq_div_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_div_cell: one bit of a restoring divider
// Compares the remainder with the shifted divisor, emits one quotient bit.
// ----------------------------------------------------------------------------
module rmq_div_cell #(
  parameter int Step = 0
) (
  input  logic                        clk,
  input  rmq_pkg::div_beat_t          in_beat,
  input  logic [rmq_pkg::DenW-1:0]    den,
  output rmq_pkg::div_beat_t          out_beat
);
  import rmq_pkg::*;

  localparam int Bit = QuoW - 1 - Step;

  logic [NumW+DenW-1:0] part;
  logic [NumW+DenW-1:0] den_sh;
  div_beat_t            beat_next;

  // rem holds the running remainder, quo the quotient bits found so far
  always_comb begin
    part      = {{DenW{1'b0}}, in_beat.rem};
    den_sh    = {{NumW{1'b0}}, den} << Bit;
    beat_next = in_beat;
    if (part >= den_sh) begin
      beat_next.rem = NumW'(part - den_sh);
      beat_next.quo = in_beat.quo | (QuoW'(1) << Bit);
    end
  end

  always_ff @(posedge clk) begin
    out_beat <= beat_next;
  end

endmodule

/* rtl/rmq_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_divider: chain of divide cells for one scaled term
// Forms |D|<<15 + B over 2B, rounds, applies the sign and saturates.
// ----------------------------------------------------------------------------
module rmq_divider (
  input  logic                              clk,
  input  logic signed [rmq_pkg::TermW-1:0] d,
  input  logic [rmq_pkg::RootW-1:0]        big,
  output logic signed [rmq_pkg::ElemW-1:0] q
);
  import rmq_pkg::*;

  div_beat_t            chain [QuoW+1];
  logic [DenW-1:0]      den   [QuoW+1];
  logic                 neg   [QuoW+1];
  logic [TermW-1:0]     mag;
  logic [QuoW-1:0]      res;
  logic signed [QuoW+1:0] sres;

  always_comb begin
    mag = d[TermW-1] ? TermW'(-d) : TermW'(d);
    chain[0].rem = NumW'({mag, 15'd0}) + NumW'(big);
    chain[0].quo = '0;
    den[0] = {big, 1'b0};
    neg[0] = d[TermW-1];
  end

  for (genvar i = 0; i < QuoW; i++) begin : g_cell
    rmq_div_cell #(.Step(i)) u_cell (
      .clk(clk), .in_beat(chain[i]), .den(den[i]), .out_beat(chain[i+1])
    );
    always_ff @(posedge clk) begin
      den[i+1] <= den[i];
      neg[i+1] <= neg[i];
    end
  end

  always_comb begin
    res  = chain[QuoW].quo;
    sres = neg[QuoW] ? -$signed({2'b00, res}) : $signed({2'b00, res});
    if (sres > $signed((QuoW+2)'(131071))) q = 18'sd131071;
    else if (sres < -$signed((QuoW+2)'(131072))) q = -18'sd131072;
    else q = ElemW'(sres);
  end

endmodule

/* rtl/rotation_matrix_to_quaternion_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_top: rotation matrix to unit quaternion
// Shepperd's method in Q1.16 on chains of square root and divide cells.
//
// Usage: drive m11..m33 and pulse start; busy is always low, so one matrix
// is taken every cycle. Each result appears on qx, qy, qz, qw, branch_taken
// and bad_matrix for one cycle with done high, after its start beat has
// passed 1 select stage, 18 square root cells, 1 register, 35 divide
// cells and 1 output register. Throughput is one matrix per cycle; the
// cell chains set the latency. Results leave in order.
// The receiver cannot stall, so nothing is held back. Reset clears the valid
// chain and done; data registers are not reset. A bad matrix (root argument
// not positive) gives zero components with bad_matrix high.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic signed [17:0]  m11, m12, m13, m21, m22, m23, m31, m32, m33,
  output logic                done,
  output logic signed [17:0]  qx, qy, qz, qw,
  output logic [1:0]          branch_taken,
  output logic                bad_matrix
);
  import rmq_pkg::*;

  localparam int SqLat  = RootW;
  localparam int DivLat = QuoW;
  localparam int SideLat = SqLat + 1 + DivLat;

  logic signed [TermW-1:0] t, arg;
  side_t                   sel_next;
  logic [RadW-1:0]         rad_next;
  side_t                   side [SideLat+1];
  sqrt_beat_t              sq [SqLat+1];
  logic [RootW-1:0]        big;
  logic signed [TermW-1:0] dd0, dd1, dd2;
  logic signed [ElemW-1:0] r0, r1, r2, bigs;
  logic [RootW-1:0]        big_hold [DivLat+1];

  assign busy = 1'b0;

  always_comb begin
    t = TermW'(m11) + TermW'(m22) + TermW'(m33);
    sel_next.valid = start;
    if (t > 0) begin
      sel_next.br = BR_TRACE;
      arg = t + TermW'(65536);
      sel_next.d0 = TermW'(m23) - TermW'(m32);
      sel_next.d1 = TermW'(m31) - TermW'(m13);
      sel_next.d2 = TermW'(m12) - TermW'(m21);
    end else if (m11 >= m22 && m11 >= m33) begin
      sel_next.br = BR_X;
      arg = TermW'(65536) + TermW'(m11) - TermW'(m22) - TermW'(m33);
      sel_next.d0 = TermW'(m12) + TermW'(m21);
      sel_next.d1 = TermW'(m13) + TermW'(m31);
      sel_next.d2 = TermW'(m23) - TermW'(m32);
    end else if (m22 > m33) begin
      sel_next.br = BR_Y;
      arg = TermW'(65536) + TermW'(m22) - TermW'(m11) - TermW'(m33);
      sel_next.d0 = TermW'(m21) + TermW'(m12);
      sel_next.d1 = TermW'(m32) + TermW'(m23);
      sel_next.d2 = TermW'(m31) - TermW'(m13);
    end else begin
      sel_next.br = BR_Z;
      arg = TermW'(65536) + TermW'(m33) - TermW'(m11) - TermW'(m22);
      sel_next.d0 = TermW'(m31) + TermW'(m13);
      sel_next.d1 = TermW'(m32) + TermW'(m23);
      sel_next.d2 = TermW'(m12) - TermW'(m21);
    end
    sel_next.bad = (arg <= 0);
    rad_next = sel_next.bad ? RadW'(1 << 14) :
               {{(RadW-TermW-14){1'b0}}, arg, 14'd0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side[0].valid <= 1'b0;
    end else begin
      side[0].valid <= sel_next.valid;
    end
    side[0].br  <= sel_next.br;
    side[0].bad <= sel_next.bad;
    side[0].d0  <= sel_next.d0;
    side[0].d1  <= sel_next.d1;
    side[0].d2  <= sel_next.d2;
    sq[0].rad   <= rad_next;
    sq[0].rem   <= '0;
    sq[0].root  <= '0;
  end

  for (genvar i = 0; i < SqLat; i++) begin : g_sq
    rmq_sqrt_cell #(.Step(i)) u_sq (.clk(clk), .in_beat(sq[i]), .out_beat(sq[i+1]));
  end

  for (genvar i = 0; i < SideLat; i++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) begin
        side[i+1].valid <= 1'b0;
      end else begin
        side[i+1].valid <= side[i].valid;
      end
      side[i+1].br  <= side[i].br;
      side[i+1].bad <= side[i].bad;
      side[i+1].d0  <= side[i].d0;
      side[i+1].d1  <= side[i].d1;
      side[i+1].d2  <= side[i].d2;
    end
  end

  always_ff @(posedge clk) begin
    big <= (sq[SqLat].root == '0) ? RootW'(1) : sq[SqLat].root;
    dd0 <= side[SqLat].d0;
    dd1 <= side[SqLat].d1;
    dd2 <= side[SqLat].d2;
  end

  assign big_hold[0] = big;
  for (genvar i = 0; i < DivLat; i++) begin : g_big
    always_ff @(posedge clk) begin
      big_hold[i+1] <= big_hold[i];
    end
  end

  rmq_divider u_div0 (.clk(clk), .d(dd0), .big(big), .q(r0));
  rmq_divider u_div1 (.clk(clk), .d(dd1), .big(big), .q(r1));
  rmq_divider u_div2 (.clk(clk), .d(dd2), .big(big), .q(r2));

  assign bigs = big_hold[DivLat][RootW-1] ? 18'sd131071 : $signed(big_hold[DivLat]);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= side[SideLat].valid;
    end
    branch_taken <= side[SideLat].br;
    bad_matrix   <= side[SideLat].bad;
    if (side[SideLat].bad) begin
      qx <= '0; qy <= '0; qz <= '0; qw <= '0;
    end else begin
      case (side[SideLat].br)
        BR_TRACE: begin qx <= r0;   qy <= r1;   qz <= r2;   qw <= bigs; end
        BR_X:     begin qx <= bigs; qy <= r0;   qz <= r1;   qw <= r2;   end
        BR_Y:     begin qx <= r0;   qy <= bigs; qz <= r1;   qw <= r2;   end
        default:  begin qx <= r0;   qy <= r1;   qz <= bigs; qw <= r2;   end
      endcase
    end
  end

endmodule
